@@ design/tcrc_pkg.sv @@
package tcrc_pkg;

    localparam int MAX_VERTICES_DEF = 64;

    localparam int VERTEX_W  = 6;
    localparam int COUNT_W   = 7;
    localparam int MASK_W    = 64;
    localparam int CMD_W     = 2;
    localparam int S_TDATA_W = 16;
    localparam int M_TDATA_W = 72;

    localparam int APB_AW = 3;
    localparam int APB_DW = 32;

    // Register index as decoded from paddr[2].
    localparam logic REG_NUM_VERTICES = 1'b0;
    localparam logic [COUNT_W-1:0] NUM_VERTICES_RESET = 7'd64;

    typedef enum logic [CMD_W-1:0] {
        CMD_CLEAR    = 2'd0,
        CMD_ADD_EDGE = 2'd1,
        CMD_COMPUTE  = 2'd2
    } cmd_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EDGE,
        ST_PIVOT,
        ST_GRAB,
        ST_SWEEP,
        ST_TEST_START,
        ST_TEST,
        ST_FINISH
    } state_t;

endpackage

@@ design/tcrc_ram.sv @@
module tcrc_ram #(
    parameter int WIDTH = tcrc_pkg::MAX_VERTICES_DEF,
    parameter int DEPTH = tcrc_pkg::MAX_VERTICES_DEF
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] ram_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            ram_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= ram_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ design/transitive_closure_rank_count_unit.sv @@
// Channel   Direction  Handshake            Content
// s_*       in         s_tvalid / s_tready  command in s_tuser, edge endpoints in s_tdata
// m_*       out        m_tvalid / m_tready  determined count and mask in m_tdata
// APB       in         psel / penable       num_vertices at byte address 0
//
// Clear uses the accepting cycle, then one memory row per cycle across all rows.
// The same row pass runs after reset, and no beat is accepted meanwhile. Add edge reads
// the two rows in the accepting cycle and writes them back in ST_EDGE. Compute with n
// vertices in use does, per pivot, one pivot read, a capture of the pivot rows and n row
// read-modify-writes on both row memories, then one pass of n reads to test each vertex.
// A result waiting in the output register only holds up the end of the next compute.
module transitive_closure_rank_count_unit #(
    parameter int MAX_VERTICES = tcrc_pkg::MAX_VERTICES_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,

    input  logic                            s_tvalid,
    output logic                            s_tready,
    // [5:0] from_vertex, [11:6] to_vertex, [15:12] zero
    input  logic [tcrc_pkg::S_TDATA_W-1:0]  s_tdata,
    // [1:0] command
    input  logic [tcrc_pkg::CMD_W-1:0]      s_tuser,

    output logic                            m_tvalid,
    input  logic                            m_tready,
    // [6:0] determined_count, [70:7] determined_mask, [71] zero
    output logic [tcrc_pkg::M_TDATA_W-1:0]  m_tdata,

    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [tcrc_pkg::APB_AW-1:0]     paddr,
    input  logic [tcrc_pkg::APB_DW-1:0]     pwdata,
    output logic [tcrc_pkg::APB_DW-1:0]     prdata,
    output logic                            pready
);

    localparam int VW = $clog2(MAX_VERTICES);
    localparam int CW = $clog2(MAX_VERTICES + 1);
    localparam logic [MAX_VERTICES-1:0] ONE_ROW = {{(MAX_VERTICES-1){1'b0}}, 1'b1};
    localparam logic [MAX_VERTICES-1:0] ALL_ROW = {MAX_VERTICES{1'b1}};

    tcrc_pkg::state_t state_reg, state_next;

    logic [tcrc_pkg::COUNT_W-1:0] num_vertices_reg;

    logic [CW-1:0] n_reg, n_next;
    logic [CW-1:0] k_reg, k_next;
    logic [CW-1:0] i_reg, i_next;
    logic [VW-1:0] pend_reg, pend_next;
    logic [VW-1:0] clr_reg, clr_next;
    logic [VW-1:0] src_reg, src_next;
    logic [VW-1:0] dst_reg, dst_next;

    logic [MAX_VERTICES-1:0] piv_r_reg, piv_r_next;
    logic [MAX_VERTICES-1:0] piv_t_reg, piv_t_next;
    logic [MAX_VERTICES-1:0] unused_reg, unused_next;

    logic [CW-1:0]                count_reg, count_next;
    logic [tcrc_pkg::MASK_W-1:0]  mask_reg, mask_next;

    logic                         out_valid_reg, out_valid_next;
    logic [tcrc_pkg::COUNT_W-1:0] out_count_reg, out_count_next;
    logic [tcrc_pkg::MASK_W-1:0]  out_mask_reg, out_mask_next;

    // Forward rows (bit j of row i: i reaches j) and transposed rows (bit i of row j).
    logic                    wr_en, rd_en;
    logic [VW-1:0]           wr_addr_r, wr_addr_t, rd_addr_r, rd_addr_t;
    logic [MAX_VERTICES-1:0] wr_data_r, wr_data_t, rd_data_r, rd_data_t;

    logic                           accept;
    tcrc_pkg::cmd_t                 cmd;
    logic [tcrc_pkg::VERTEX_W-1:0]  from_vertex, to_vertex;
    logic                           edge_ok;
    logic [CW-1:0]                  n_in;
    logic                           good;
    logic                           cfg_write;

    assign cmd         = tcrc_pkg::cmd_t'(s_tuser);
    assign from_vertex = s_tdata[5:0];
    assign to_vertex   = s_tdata[11:6];
    assign s_tready    = (state_reg == tcrc_pkg::ST_IDLE);
    assign accept      = s_tvalid && s_tready;

    assign edge_ok = (32'(from_vertex) < 32'(MAX_VERTICES))
                  && (32'(to_vertex) < 32'(MAX_VERTICES));

    assign n_in = (32'(num_vertices_reg) > 32'(MAX_VERTICES)) ? CW'(MAX_VERTICES)
                                                               : CW'(num_vertices_reg);

    // A vertex passes when every in-use vertex is reached from it or reaches it.
    assign good = &(rd_data_r | rd_data_t | (ONE_ROW << pend_reg) | unused_reg);

    assign cfg_write = psel && penable && pwrite && pready;
    assign pready    = 1'b1;
    assign prdata    = (paddr[2] == tcrc_pkg::REG_NUM_VERTICES)
                     ? {{(tcrc_pkg::APB_DW-tcrc_pkg::COUNT_W){1'b0}}, num_vertices_reg}
                     : '0;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0, out_mask_reg, out_count_reg};

    tcrc_ram #(
        .WIDTH (MAX_VERTICES),
        .DEPTH (MAX_VERTICES)
    ) u_fwd_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr_r),
        .wr_data (wr_data_r),
        .rd_en   (rd_en),
        .rd_addr (rd_addr_r),
        .rd_data (rd_data_r)
    );

    tcrc_ram #(
        .WIDTH (MAX_VERTICES),
        .DEPTH (MAX_VERTICES)
    ) u_rev_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr_t),
        .wr_data (wr_data_t),
        .rd_en   (rd_en),
        .rd_addr (rd_addr_t),
        .rd_data (rd_data_t)
    );

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            tcrc_pkg::ST_CLEAR:
            begin
                if (clr_reg == VW'(MAX_VERTICES - 1))
                begin
                    state_next = tcrc_pkg::ST_IDLE;
                end
            end
            tcrc_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    case (cmd)
                        tcrc_pkg::CMD_CLEAR:
                        begin
                            state_next = tcrc_pkg::ST_CLEAR;
                        end
                        tcrc_pkg::CMD_ADD_EDGE:
                        begin
                            if (edge_ok)
                            begin
                                state_next = tcrc_pkg::ST_EDGE;
                            end
                        end
                        tcrc_pkg::CMD_COMPUTE:
                        begin
                            state_next = (n_in == '0) ? tcrc_pkg::ST_FINISH
                                                      : tcrc_pkg::ST_PIVOT;
                        end
                        default:
                        begin
                            state_next = tcrc_pkg::ST_IDLE;
                        end
                    endcase
                end
            end
            tcrc_pkg::ST_EDGE:
            begin
                state_next = tcrc_pkg::ST_IDLE;
            end
            tcrc_pkg::ST_PIVOT:
            begin
                state_next = tcrc_pkg::ST_GRAB;
            end
            tcrc_pkg::ST_GRAB:
            begin
                state_next = tcrc_pkg::ST_SWEEP;
            end
            tcrc_pkg::ST_SWEEP:
            begin
                if (i_reg == n_reg)
                begin
                    state_next = (k_reg + CW'(1) == n_reg) ? tcrc_pkg::ST_TEST_START
                                                           : tcrc_pkg::ST_PIVOT;
                end
            end
            tcrc_pkg::ST_TEST_START:
            begin
                state_next = tcrc_pkg::ST_TEST;
            end
            tcrc_pkg::ST_TEST:
            begin
                if (i_reg == n_reg)
                begin
                    state_next = tcrc_pkg::ST_FINISH;
                end
            end
            tcrc_pkg::ST_FINISH:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    state_next = tcrc_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = tcrc_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        n_next         = n_reg;
        k_next         = k_reg;
        i_next         = i_reg;
        pend_next      = pend_reg;
        clr_next       = clr_reg;
        src_next       = src_reg;
        dst_next       = dst_reg;
        piv_r_next     = piv_r_reg;
        piv_t_next     = piv_t_reg;
        unused_next    = unused_reg;
        count_next     = count_reg;
        mask_next      = mask_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_count_next = out_count_reg;
        out_mask_next  = out_mask_reg;

        wr_en     = 1'b0;
        wr_addr_r = '0;
        wr_addr_t = '0;
        wr_data_r = '0;
        wr_data_t = '0;
        rd_en     = 1'b0;
        rd_addr_r = '0;
        rd_addr_t = '0;

        case (state_reg)
            tcrc_pkg::ST_CLEAR:
            begin
                wr_en     = 1'b1;
                wr_addr_r = clr_reg;
                wr_addr_t = clr_reg;
                clr_next  = clr_reg + VW'(1);
            end
            tcrc_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    case (cmd)
                        tcrc_pkg::CMD_CLEAR:
                        begin
                            clr_next = '0;
                        end
                        tcrc_pkg::CMD_ADD_EDGE:
                        begin
                            src_next  = VW'(from_vertex);
                            dst_next  = VW'(to_vertex);
                            rd_en     = edge_ok;
                            rd_addr_r = VW'(from_vertex);
                            rd_addr_t = VW'(to_vertex);
                        end
                        tcrc_pkg::CMD_COMPUTE:
                        begin
                            n_next      = n_in;
                            unused_next = ALL_ROW << n_in;
                            k_next      = '0;
                            count_next  = '0;
                            mask_next   = '0;
                        end
                        default:
                        begin
                            n_next = n_reg;
                        end
                    endcase
                end
            end
            tcrc_pkg::ST_EDGE:
            begin
                wr_en     = 1'b1;
                wr_addr_r = src_reg;
                wr_addr_t = dst_reg;
                wr_data_r = rd_data_r | (ONE_ROW << dst_reg);
                wr_data_t = rd_data_t | (ONE_ROW << src_reg);
            end
            tcrc_pkg::ST_PIVOT:
            begin
                rd_en     = 1'b1;
                rd_addr_r = k_reg[VW-1:0];
                rd_addr_t = k_reg[VW-1:0];
            end
            tcrc_pkg::ST_GRAB:
            begin
                piv_r_next = rd_data_r;
                piv_t_next = rd_data_t;
                rd_en      = 1'b1;
                i_next     = CW'(1);
                pend_next  = '0;
            end
            tcrc_pkg::ST_SWEEP:
            begin
                // Row pend_reg picks up the pivot row when it already reaches the pivot.
                wr_en     = 1'b1;
                wr_addr_r = pend_reg;
                wr_addr_t = pend_reg;
                wr_data_r = rd_data_r | (rd_data_r[k_reg[VW-1:0]] ? piv_r_reg : '0);
                wr_data_t = rd_data_t | (rd_data_t[k_reg[VW-1:0]] ? piv_t_reg : '0);
                if (i_reg != n_reg)
                begin
                    rd_en     = 1'b1;
                    rd_addr_r = i_reg[VW-1:0];
                    rd_addr_t = i_reg[VW-1:0];
                    pend_next = i_reg[VW-1:0];
                    i_next    = i_reg + CW'(1);
                end
                else
                begin
                    k_next = k_reg + CW'(1);
                end
            end
            tcrc_pkg::ST_TEST_START:
            begin
                rd_en     = 1'b1;
                i_next    = CW'(1);
                pend_next = '0;
            end
            tcrc_pkg::ST_TEST:
            begin
                if (good)
                begin
                    count_next = count_reg + CW'(1);
                    mask_next  = mask_reg | (64'd1 << pend_reg);
                end
                if (i_reg != n_reg)
                begin
                    rd_en     = 1'b1;
                    rd_addr_r = i_reg[VW-1:0];
                    rd_addr_t = i_reg[VW-1:0];
                    pend_next = i_reg[VW-1:0];
                    i_next    = i_reg + CW'(1);
                end
            end
            tcrc_pkg::ST_FINISH:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    out_valid_next = 1'b1;
                    out_count_next = tcrc_pkg::COUNT_W'(count_reg);
                    out_mask_next  = mask_reg;
                end
            end
            default:
            begin
                wr_en = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= tcrc_pkg::ST_CLEAR;
            clr_reg          <= '0;
            k_reg            <= '0;
            i_reg            <= '0;
            out_valid_reg    <= 1'b0;
            num_vertices_reg <= tcrc_pkg::NUM_VERTICES_RESET;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            k_reg         <= k_next;
            i_reg         <= i_next;
            out_valid_reg <= out_valid_next;
            if (cfg_write && (paddr[2] == tcrc_pkg::REG_NUM_VERTICES))
            begin
                num_vertices_reg <= pwdata[tcrc_pkg::COUNT_W-1:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg         <= n_next;
        pend_reg      <= pend_next;
        src_reg       <= src_next;
        dst_reg       <= dst_next;
        piv_r_reg     <= piv_r_next;
        piv_t_reg     <= piv_t_next;
        unused_reg    <= unused_next;
        count_reg     <= count_next;
        mask_reg      <= mask_next;
        out_count_reg <= out_count_next;
        out_mask_reg  <= out_mask_next;
    end

endmodule
